// ===== rtl/cre_pkg.sv =====
`timescale 1ns / 1ps

package cre_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OPERATION    = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ELEMENT_TYPE = 4'd1;

   // operation codes
   localparam logic [2:0] OP_SUM    = 3'd0;
   localparam logic [2:0] OP_MIN    = 3'd1;
   localparam logic [2:0] OP_MAX    = 3'd2;
   localparam logic [2:0] OP_PROD   = 3'd3;
   localparam logic [2:0] OP_ARGMIN = 3'd4;
   localparam logic [2:0] OP_ARGMAX = 3'd5;

   // element type: bits [2:1] select the width, bit 0 marks unsigned
   localparam logic [2:0] ELEM_I64 = 3'd6;
   localparam logic [1:0] ELEM_W8  = 2'd0;
   localparam logic [1:0] ELEM_W16 = 2'd1;
   localparam logic [1:0] ELEM_W32 = 2'd2;
   localparam logic [1:0] ELEM_W64 = 2'd3;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OPC_SUM  = 2'd0,
      OPC_MIN  = 2'd1,
      OPC_MAX  = 2'd2,
      OPC_PROD = 2'd3
   } opclass_type;

   typedef struct packed {
      logic [63:0] element_value;
      logic        last_element;
   } req_type;

   typedef struct packed {
      logic [63:0] result_value;
      logic [31:0] result_index;
      logic        result_unsigned;
   } rsp_type;

   // classified element handed from front to back
   typedef struct packed {
      logic [63:0] value;
      opclass_type opclass;
      logic        arg;
      logic        is_unsigned;
      logic        first;
      logic        last;
   } item_type;

   function automatic logic [63:0] extend_element(logic [63:0] raw, logic [2:0] etype);
      logic [63:0] r;
      unique case (etype[2:1])
         ELEM_W8:  r = etype[0] ? {56'b0, raw[7:0]}  : {{56{raw[7]}}, raw[7:0]};
         ELEM_W16: r = etype[0] ? {48'b0, raw[15:0]} : {{48{raw[15]}}, raw[15:0]};
         ELEM_W32: r = etype[0] ? {32'b0, raw[31:0]} : {{32{raw[31]}}, raw[31:0]};
         ELEM_W64: r = raw;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/column_reduce_engine.sv =====
`timescale 1ns / 1ps

// channel   direction  ports                        carries
// req       in         req_valid/ready, req_data    one column element and last flag
// rsp       out        rsp_valid/ready, rsp_data    reduced value, index, unsigned flag
// csr       in         csr_valid/ready, csr_index,  operation and element type writes
//                      csr_wdata
//
// sum, min, max, argmin and argmax take one cycle per element, but a last element waits
// while the result register is held; product steps the single 32x32 multiplier through
// three partial products and takes no new element until they are done. an element is
// registered in the two-entry queue between the front and the execute stage (so either
// side stalls alone) before it reaches the result register, held while rsp_ready is low.
// reset is synchronous; it clears the run, the queue and the output valid, and sets the
// operation to sum and the element type to i64.

module column_reduce_engine #(
   parameter int INDEX_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cre_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cre_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cre_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [2:0]                          csr_wdata
);

   localparam int ENTRY_WIDTH = $bits(cre_pkg::item_type) + INDEX_WIDTH;

   logic                   fq_valid, fq_ready;
   cre_pkg::item_type      fq_item;
   logic [INDEX_WIDTH-1:0] fq_pos;
   logic                   bq_valid, bq_ready;
   logic [ENTRY_WIDTH-1:0] bq_data;
   cre_pkg::item_type      bq_item;
   logic [INDEX_WIDTH-1:0] bq_pos;

   assign bq_item = cre_pkg::item_type'(bq_data[$bits(cre_pkg::item_type)-1:0]);
   assign bq_pos  = bq_data[ENTRY_WIDTH-1:$bits(cre_pkg::item_type)];

   cre_front #(
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_valid   (fq_valid),
      .q_ready   (fq_ready),
      .q_item    (fq_item),
      .q_pos     (fq_pos)
   );

   cre_queue #(
      .WIDTH (ENTRY_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  ({fq_pos, fq_item}),
      .pop_valid  (bq_valid),
      .pop_ready  (bq_ready),
      .pop_data   (bq_data)
   );

   cre_exec #(
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_exec (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (bq_valid),
      .q_ready   (bq_ready),
      .q_item    (bq_item),
      .q_pos     (bq_pos),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/cre_front.sv =====
`timescale 1ns / 1ps

module cre_front #(
   parameter int INDEX_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  cre_pkg::req_type                   req_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cre_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [2:0]                         csr_wdata,
   output logic                               q_valid,
   input  logic                               q_ready,
   output cre_pkg::item_type                  q_item,
   output logic [INDEX_WIDTH-1:0]             q_pos
);

   logic [2:0]             operation_ff, operation_in;
   logic [2:0]             etype_ff, etype_in;
   logic [INDEX_WIDTH-1:0] count_ff, count_in;
   logic                   started_ff, started_in;
   logic                   accept;

   assign csr_ready = 1'b1;
   assign req_ready = q_ready;
   assign q_valid   = req_valid;
   assign accept    = req_valid && q_ready;
   assign q_pos     = count_ff;

   always_comb begin
      q_item.value       = cre_pkg::extend_element(req_data.element_value, etype_ff);
      q_item.is_unsigned = etype_ff[0];
      q_item.first       = !started_ff;
      q_item.last        = req_data.last_element;
      q_item.arg         = 1'b0;
      unique case (operation_ff)
         cre_pkg::OP_MIN:    q_item.opclass = cre_pkg::OPC_MIN;
         cre_pkg::OP_MAX:    q_item.opclass = cre_pkg::OPC_MAX;
         cre_pkg::OP_PROD:   q_item.opclass = cre_pkg::OPC_PROD;
         cre_pkg::OP_ARGMIN: begin
            q_item.opclass = cre_pkg::OPC_MIN;
            q_item.arg     = 1'b1;
         end
         cre_pkg::OP_ARGMAX: begin
            q_item.opclass = cre_pkg::OPC_MAX;
            q_item.arg     = 1'b1;
         end
         default:            q_item.opclass = cre_pkg::OPC_SUM;
      endcase
   end

   always_comb begin
      operation_in = operation_ff;
      etype_in     = etype_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == cre_pkg::CSR_OPERATION) begin
            operation_in = csr_wdata;
         end
         if (csr_index == cre_pkg::CSR_ELEMENT_TYPE) begin
            etype_in = csr_wdata;
         end
      end
      count_in   = count_ff;
      started_in = started_ff;
      if (accept) begin
         // position wraps naturally at the counter width
         count_in   = req_data.last_element ? '0 : count_ff + 1'b1;
         started_in = !req_data.last_element;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         operation_ff <= cre_pkg::OP_SUM;
         etype_ff     <= cre_pkg::ELEM_I64;
         count_ff     <= '0;
         started_ff   <= 1'b0;
      end else begin
         operation_ff <= operation_in;
         etype_ff     <= etype_in;
         count_ff     <= count_in;
         started_ff   <= started_in;
      end
   end

endmodule

// ===== rtl/cre_queue.sv =====
`timescale 1ns / 1ps

module cre_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_WIDTH   = $clog2(cre_pkg::QUEUE_DEPTH);
   localparam int COUNT_WIDTH = $clog2(cre_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0]   LAST_PTR  = PTR_WIDTH'(cre_pkg::QUEUE_DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(cre_pkg::QUEUE_DEPTH);

   logic [WIDTH-1:0]       entry_ff [cre_pkg::QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   push, pop;

   assign push_ready = count_ff != FULL_COUNT;
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/cre_exec.sv =====
`timescale 1ns / 1ps

module cre_exec #(
   parameter int INDEX_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_ready,
   input  cre_pkg::item_type      q_item,
   input  logic [INDEX_WIDTH-1:0] q_pos,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cre_pkg::rsp_type       rsp_data
);

   typedef enum logic [3:0] {
      S_READY = 4'b0001,
      S_MUL1  = 4'b0010,
      S_MUL2  = 4'b0100,
      S_MUL3  = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [63:0]            acc_ff, acc_in;
   logic [INDEX_WIDTH-1:0] best_ff, best_in;
   logic [63:0]            opb_ff, opb_in;
   logic [63:0]            mreg_ff, mreg_in;
   logic [63:0]            sum_ff, sum_in;
   logic                   last_ff, last_in;
   logic                   uns_ff, uns_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   cre_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   logic                   out_free, mul_start, pop;
   logic [63:0]            x_key, acc_key;
   logic                   x_lt, acc_lt;
   logic [63:0]            step_acc;
   logic [INDEX_WIDTH-1:0] step_best;
   logic [63:0]            best_wide;
   logic [31:0]            mul_a, mul_b;
   logic [63:0]            mul_prod;
   logic [63:0]            prod_final;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign mul_start = (q_item.opclass == cre_pkg::OPC_PROD) && !q_item.first;
   assign q_ready   = (state_ff == S_READY) && (mul_start || !q_item.last || out_free);
   assign pop       = q_valid && q_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // signed compare as unsigned with the sign bit flipped
   assign x_key   = {q_item.value[63] ^ !q_item.is_unsigned, q_item.value[62:0]};
   assign acc_key = {acc_ff[63] ^ !q_item.is_unsigned, acc_ff[62:0]};
   assign x_lt    = x_key < acc_key;
   assign acc_lt  = acc_key < x_key;

   always_comb begin
      step_acc  = acc_ff;
      step_best = best_ff;
      if (q_item.first) begin
         step_acc  = q_item.value;
         step_best = q_pos;
      end else begin
         unique case (q_item.opclass)
            cre_pkg::OPC_SUM:  step_acc = acc_ff + q_item.value;
            cre_pkg::OPC_MIN: begin
               if (x_lt) begin
                  step_acc  = q_item.value;
                  step_best = q_pos;
               end
            end
            cre_pkg::OPC_MAX: begin
               if (acc_lt) begin
                  step_acc  = q_item.value;
                  step_best = q_pos;
               end
            end
            cre_pkg::OPC_PROD: step_acc = acc_ff;
         endcase
      end
      best_wide = 64'(step_best);
   end

   // one 32x32 multiplier, three partial products of the low 64 bits
   always_comb begin
      unique case (state_ff)
         S_MUL1: begin
            mul_a = acc_ff[31:0];
            mul_b = opb_ff[63:32];
         end
         S_MUL2: begin
            mul_a = acc_ff[63:32];
            mul_b = opb_ff[31:0];
         end
         default: begin
            mul_a = acc_ff[31:0];
            mul_b = q_item.value[31:0];
         end
      endcase
   end

   assign mul_prod   = mul_a * mul_b;
   assign prod_final = sum_ff + {mreg_ff[31:0], 32'b0};

   always_comb begin
      state_in    = state_ff;
      acc_in      = acc_ff;
      best_in     = best_ff;
      opb_in      = opb_ff;
      mreg_in     = (state_ff == S_MUL3) ? mreg_ff : mul_prod;
      sum_in      = sum_ff;
      last_in     = last_ff;
      uns_in      = uns_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_READY: begin
            if (pop) begin
               if (mul_start) begin
                  state_in = S_MUL1;
                  opb_in   = q_item.value;
                  last_in  = q_item.last;
                  uns_in   = q_item.is_unsigned;
               end else begin
                  acc_in  = step_acc;
                  best_in = step_best;
                  if (q_item.last) begin
                     rsp_valid_in                = 1'b1;
                     rsp_data_in.result_value    = step_acc;
                     rsp_data_in.result_index    = q_item.arg ? best_wide[31:0] : 32'b0;
                     rsp_data_in.result_unsigned = q_item.is_unsigned;
                  end
               end
            end
         end
         S_MUL1: begin
            sum_in   = mreg_ff;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            sum_in   = prod_final;
            state_in = S_MUL3;
         end
         S_MUL3: begin
            if (!last_ff || out_free) begin
               acc_in   = prod_final;
               state_in = S_READY;
               if (last_ff) begin
                  rsp_valid_in                = 1'b1;
                  rsp_data_in.result_value    = prod_final;
                  rsp_data_in.result_index    = 32'b0;
                  rsp_data_in.result_unsigned = uns_ff;
               end
            end
         end
         default: state_in = S_READY;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      best_ff     <= best_in;
      opb_ff      <= opb_in;
      mreg_ff     <= mreg_in;
      sum_ff      <= sum_in;
      last_ff     <= last_in;
      uns_ff      <= uns_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_READY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_mul1_to_mul2: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL1) |=> (state_ff == S_MUL2))
      else $error("product sequence skipped second partial product");

   a_mul2_to_mul3: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL2) |=> (state_ff == S_MUL3))
      else $error("product sequence skipped third partial product");

   a_prod_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL3 && last_ff && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_MUL3))
      else $error("product result left while output still held");

endmodule

// ===== sim/tb_column_reduce_engine.sv =====
`timescale 1ns / 1ps

module tb_column_reduce_engine;

   // element types beyond the one the package names
   localparam logic [2:0] ET_I8  = 3'd0;
   localparam logic [2:0] ET_U8  = 3'd1;
   localparam logic [2:0] ET_I16 = 3'd2;
   localparam logic [2:0] ET_U16 = 3'd3;
   localparam logic [2:0] ET_I32 = 3'd4;
   localparam logic [2:0] ET_U32 = 3'd5;
   localparam logic [2:0] ET_U64 = 3'd7;

   // undefined operation codes, folded as sum
   localparam logic [2:0] OP_ALIAS_6 = 3'd6;
   localparam logic [2:0] OP_ALIAS_7 = 3'd7;

   localparam int CSR_W = cre_pkg::CSR_INDEX_WIDTH;
   localparam logic [CSR_W-1:0] CSR_SPARE_LO = cre_pkg::CSR_ELEMENT_TYPE + 1'b1;
   localparam logic [CSR_W-1:0] CSR_SPARE_HI = '1;

   localparam int IDX_W         = 32;
   localparam int IDLE_PCT      = 27;
   localparam int SETTLE_CYCLES = 24;
   localparam int TAIL_CYCLES   = 40;
   localparam int HOLD_CYCLES   = 200;
   localparam int HOLD_AT       = 1;
   localparam int STEADY_FROM   = 700;
   localparam int STEADY_TO     = 950;
   localparam int STALL_LIMIT   = 4000;
   localparam int ITEM_TARGET   = 1650;

   typedef enum logic [1:0] {
      ACT_ELEMENT,
      ACT_CSR,
      ACT_DRAIN
   } work_kind_type;

   typedef struct {
      work_kind_type               kind;
      cre_pkg::req_type            req;
      logic [CSR_W-1:0]            index;
      logic [2:0]                  wdata;
   } work_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   cre_pkg::req_type            req_data = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   cre_pkg::rsp_type            rsp_data;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_W-1:0]            csr_index = '0;
   logic [2:0]                  csr_wdata = '0;

   column_reduce_engine #(
      .INDEX_WIDTH(IDX_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   work_type          pending_work[$];
   cre_pkg::rsp_type  reductions_due[$];
   int          mismatches = 0;
   int          elements_sent = 0;
   int          quiet_cycles = 0;
   int          stall_cycles = 0;
   int          planned_items = 0;
   logic [2:0]  plan_et = cre_pkg::ELEM_I64;

   // predicted state of the engine
   logic [2:0]        cfg_op = cre_pkg::OP_SUM;
   logic [2:0]        cfg_et = cre_pkg::ELEM_I64;
   logic [63:0]       acc_q = '0;
   logic [IDX_W-1:0]  best_q = '0;
   logic [IDX_W-1:0]  count_q = '0;
   logic              started_q = 1'b0;

   function automatic int elem_width(logic [2:0] et);
      return 8 << et[2:1];
   endfunction

   function automatic logic [63:0] width_mask(logic [2:0] et);
      int w;
      w = elem_width(et);
      return (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
   endfunction

   function automatic logic [63:0] widen(logic [63:0] raw, logic [2:0] et);
      logic [63:0] m;
      logic [63:0] v;
      int          w;
      m = width_mask(et);
      w = elem_width(et);
      v = raw & m;
      if (!et[0] && w < 64 && v[w-1]) v = v | ~m;
      return v;
   endfunction

   function automatic bit precedes(logic [63:0] a, logic [63:0] b, logic uns);
      return uns ? (a < b) : ($signed(a) < $signed(b));
   endfunction

   // folds one element into the running column, returns 1 when the column closes
   function automatic bit fold_element(input cre_pkg::req_type elem,
                                       output cre_pkg::rsp_type res);
      logic [63:0]       x;
      logic              uns;
      logic [IDX_W-1:0]  pos;
      uns = cfg_et[0];
      x = widen(elem.element_value, cfg_et);
      pos = count_q;
      res = '0;
      if (!started_q) begin
         acc_q = x;
         best_q = pos;
         started_q = 1'b1;
      end else begin
         case (cfg_op)
            cre_pkg::OP_PROD: acc_q = acc_q * x;
            cre_pkg::OP_MIN, cre_pkg::OP_ARGMIN: begin
               if (precedes(x, acc_q, uns)) begin
                  acc_q = x;
                  best_q = pos;
               end
            end
            cre_pkg::OP_MAX, cre_pkg::OP_ARGMAX: begin
               if (precedes(acc_q, x, uns)) begin
                  acc_q = x;
                  best_q = pos;
               end
            end
            default: acc_q = acc_q + x;
         endcase
      end
      count_q = pos + 1'b1;
      if (!elem.last_element) return 1'b0;
      res.result_value = acc_q;
      res.result_index = (cfg_op == cre_pkg::OP_ARGMIN || cfg_op == cre_pkg::OP_ARGMAX) ?
                         32'(best_q) : '0;
      res.result_unsigned = uns;
      acc_q = '0;
      best_q = '0;
      count_q = '0;
      started_q = 1'b0;
      return 1'b1;
   endfunction

   function automatic bit steady_phase();
      return elements_sent >= STEADY_FROM && elements_sent < STEADY_TO;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] exp, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %h, got %h", what, exp, got);
   endtask

   task automatic push_element(logic [63:0] v, bit is_last);
      work_type w;
      w.kind = ACT_ELEMENT;
      w.req.element_value = v;
      w.req.last_element = is_last;
      w.index = '0;
      w.wdata = '0;
      pending_work.push_back(w);
      planned_items++;
   endtask

   task automatic push_csr(logic [CSR_W-1:0] idx, logic [2:0] d);
      work_type w;
      w.kind = ACT_CSR;
      w.req = '0;
      w.index = idx;
      w.wdata = d;
      pending_work.push_back(w);
      if (idx == cre_pkg::CSR_ELEMENT_TYPE) plan_et = d;
   endtask

   task automatic push_drain();
      work_type w;
      w.kind = ACT_DRAIN;
      w.req = '0;
      w.index = '0;
      w.wdata = '0;
      pending_work.push_back(w);
   endtask

   // random raw bits with the type's extremes and ties mixed in; high bits stay noisy
   function automatic logic [63:0] pick_value(logic [2:0] et, logic [63:0] prev);
      logic [63:0] m;
      logic [63:0] raw;
      logic [63:0] low;
      int          w;
      m = width_mask(et);
      w = elem_width(et);
      raw = {$urandom(), $urandom()};
      case ($urandom_range(0, 9))
         0: low = '0;
         1: low = '1;
         2: low = 64'd1 << (w - 1);
         3: low = ~(64'd1 << (w - 1));
         4: return prev;
         5: low = 64'($urandom_range(0, 3));
         default: return raw;
      endcase
      return (raw & ~m) | (low & m);
   endfunction

   task automatic build_stimulus();
      logic [2:0]                  op;
      logic [2:0]                  et;
      logic [CSR_W-1:0]            spare;
      logic [63:0]                 prev;
      int                          target;
      int                          phase;
      int                          ncols;
      int                          len;
      bit                          open_run;

      // single element and wrapping sum at reset settings
      push_element(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      // one-element columns that back up behind the held first result
      for (int k = 0; k < 8; k++) push_element(64'(k), 1'b1);
      push_element(64'h8000_0000_0000_0000, 1'b0);
      push_element(64'h8000_0000_0000_0000, 1'b0);
      push_element(64'h0000_0000_0000_0001, 1'b1);
      push_csr(cre_pkg::CSR_OPERATION, cre_pkg::OP_MAX);
      push_csr(cre_pkg::CSR_ELEMENT_TYPE, ET_U64);
      push_element(64'h0, 1'b0);
      push_element(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      push_element(64'h1, 1'b1);
      push_csr(cre_pkg::CSR_OPERATION, cre_pkg::OP_MIN);
      push_csr(cre_pkg::CSR_ELEMENT_TYPE, ET_I8);
      push_element(64'h1234_5678_9ABC_DE80, 1'b0);
      push_element(64'hFFFF_FFFF_FFFF_FF7F, 1'b1);
      push_csr(cre_pkg::CSR_OPERATION, cre_pkg::OP_PROD);
      push_csr(cre_pkg::CSR_ELEMENT_TYPE, ET_U16);
      push_element(64'hAAAA_AAAA_AAAA_FFFF, 1'b0);
      push_element(64'h0000_0000_0000_FFFF, 1'b0);
      push_element(64'h5555_5555_5555_FFFF, 1'b1);
      // ties: earliest position wins
      push_csr(cre_pkg::CSR_OPERATION, cre_pkg::OP_ARGMAX);
      push_csr(cre_pkg::CSR_ELEMENT_TYPE, ET_I32);
      push_element(64'h5, 1'b0);
      push_element(64'h7, 1'b0);
      push_element(64'h7, 1'b0);
      push_element(64'hFFFF_FFFF, 1'b1);
      push_csr(cre_pkg::CSR_OPERATION, cre_pkg::OP_ARGMIN);
      push_csr(cre_pkg::CSR_ELEMENT_TYPE, ET_U32);
      push_element(64'hFFFF_FFFF, 1'b0);
      push_element(64'h0, 1'b0);
      push_element(64'h3, 1'b0);
      push_element(64'h0, 1'b1);
      push_csr(cre_pkg::CSR_OPERATION, OP_ALIAS_7);
      push_csr(cre_pkg::CSR_ELEMENT_TYPE, ET_I16);
      push_element(64'h8000, 1'b0);
      push_element(64'h8000, 1'b1);
      // settings changed in the middle of a run
      push_csr(cre_pkg::CSR_OPERATION, cre_pkg::OP_MIN);
      push_csr(cre_pkg::CSR_ELEMENT_TYPE, ET_U8);
      push_element(64'h10, 1'b0);
      push_element(64'h05, 1'b0);
      push_csr(cre_pkg::CSR_OPERATION, cre_pkg::OP_SUM);
      push_csr(cre_pkg::CSR_ELEMENT_TYPE, cre_pkg::ELEM_I64);
      push_element(64'h03, 1'b1);

      prev = '0;
      phase = 0;
      target = planned_items + ITEM_TARGET;
      while (planned_items < target) begin
         phase++;
         if (phase % 9 == 0) push_drain();
         if ($urandom_range(0, 9) == 0)
            op = ($urandom_range(0, 1) == 0) ? OP_ALIAS_6 : OP_ALIAS_7;
         else
            op = 3'($urandom_range(cre_pkg::OP_SUM, cre_pkg::OP_ARGMAX));
         et = 3'($urandom_range(ET_I8, ET_U64));
         case ($urandom_range(0, 3))
            0: push_csr(cre_pkg::CSR_OPERATION, op);
            1: push_csr(cre_pkg::CSR_ELEMENT_TYPE, et);
            default: begin
               push_csr(cre_pkg::CSR_OPERATION, op);
               push_csr(cre_pkg::CSR_ELEMENT_TYPE, et);
            end
         endcase
         if ($urandom_range(0, 15) == 0) begin
            spare = CSR_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI));
            push_csr(spare, 3'($urandom_range(0, 7)));
         end
         ncols = $urandom_range(1, 6);
         for (int c = 0; c < ncols; c++) begin
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
            // now and then the run stays open across the next settings change
            open_run = (c == ncols - 1) && ($urandom_range(0, 6) == 0);
            for (int k = 0; k < len; k++) begin
               prev = pick_value(plan_et, prev);
               push_element(prev, (k == len - 1) && !open_run);
            end
         end
      end
      push_element(pick_value(plan_et, prev), 1'b1);
   endtask

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // driver: feeds elements and register writes from the pending queue
   always @(posedge clock) begin
      cre_pkg::rsp_type  want;
      work_type          head;
      bit                req_n;
      bit                csr_n;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         cfg_op = cre_pkg::OP_SUM;
         cfg_et = cre_pkg::ELEM_I64;
         acc_q = '0;
         best_q = '0;
         count_q = '0;
         started_q = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_n = req_valid;
         csr_n = csr_valid;
         if (quiet_cycles < SETTLE_CYCLES) quiet_cycles++;
         if (req_valid && req_ready) begin
            if (fold_element(req_data, want)) reductions_due.push_back(want);
            elements_sent++;
            quiet_cycles = 0;
            req_n = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == cre_pkg::CSR_OPERATION) cfg_op = csr_wdata;
            else if (csr_index == cre_pkg::CSR_ELEMENT_TYPE) cfg_et = csr_wdata;
            csr_n = 1'b0;
         end
         if (!req_n && !csr_n && pending_work.size() != 0) begin
            head = pending_work[0];
            if (head.kind == ACT_ELEMENT) begin
               if (steady_phase() || $urandom_range(0, 99) >= IDLE_PCT) begin
                  req_data <= head.req;
                  req_n = 1'b1;
                  void'(pending_work.pop_front());
               end
            end else if (reductions_due.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
               // engine has gone quiet, safe to touch the registers
               if (head.kind == ACT_CSR) begin
                  csr_index <= head.index;
                  csr_wdata <= head.wdata;
                  csr_n = 1'b1;
               end
               void'(pending_work.pop_front());
            end
         end
         req_valid <= req_n;
         csr_valid <= csr_n;
      end
   end

   // monitor: checks each result transfer and paces rsp_ready
   int hold_left = 0;
   bit hold_done = 1'b0;

   always @(posedge clock) begin
      cre_pkg::rsp_type want;
      bit               ready_n;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (reductions_due.size() == 0) begin
               report_mismatch("result with none due", '0, rsp_data.result_value);
            end else begin
               want = reductions_due.pop_front();
               if (rsp_data.result_value !== want.result_value)
                  report_mismatch("result_value", want.result_value, rsp_data.result_value);
               if (rsp_data.result_index !== want.result_index)
                  report_mismatch("result_index", 64'(want.result_index),
                                  64'(rsp_data.result_index));
               if (rsp_data.result_unsigned !== want.result_unsigned)
                  report_mismatch("result_unsigned", 64'(want.result_unsigned),
                                  64'(rsp_data.result_unsigned));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_n = 1'b0;
         end else if (!hold_done && elements_sent >= HOLD_AT) begin
            // long back-pressure so the engine fills and stalls req
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            ready_n = 1'b0;
         end else begin
            ready_n = steady_phase() || ($urandom_range(0, 99) >= IDLE_PCT);
         end
         rsp_ready <= ready_n;
      end
   end

   initial begin
      bit timed_out;
      int tail;
      timed_out = 1'b0;
      build_stimulus();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (!timed_out && (pending_work.size() != 0 || req_valid || csr_valid ||
                            reductions_due.size() != 0)) begin
         @(negedge clock);
         if (stall_cycles >= STALL_LIMIT) timed_out = 1'b1;
      end
      tail = 0;
      while (!timed_out && tail < TAIL_CYCLES) begin
         @(negedge clock);
         tail++;
      end
      if (timed_out) begin
         $display("tb: failure");
      end else begin
         if (reductions_due.size() != 0)
            report_mismatch("results still due", 64'(reductions_due.size()), '0);
         if (mismatches == 0) begin
            $display("tb: success");
         end else begin
            $display("tb: failure");
         end
      end
      $finish;
   end

endmodule
